// ===== hdl/rcb_pkg.sv =====
// rcb_pkg: shared constants, codes and types of the rc branch voltage-drop model
// no dependencies; imported by rcb_div and the top level
`timescale 1ns / 1ps
`default_nettype none

package rcb_pkg;

  localparam int MAX_BRANCHES = 16;
  localparam int SLOT_W       = (MAX_BRANCHES > 1) ? $clog2(MAX_BRANCHES) : 1;
  localparam int CNT_W        = $clog2(MAX_BRANCHES + 1);
  localparam int DCS_W        = 32 + CNT_W;
  localparam int TAU_W        = 48;
  localparam int PAR_W        = 32 + TAU_W + 1;
  localparam int ACC_W        = 56;
  localparam int DIVD_W       = 64;
  localparam int DIVS_W       = 49;
  localparam int DIVC_W       = $clog2(DIVD_W);

  // register select bit of the configuration port (byte address bit 2)
  localparam logic REG_SERIES = 1'b0;
  localparam logic REG_ACTIVE = 1'b1;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  localparam logic KIND_RC = 1'b0;
  localparam logic KIND_RL = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

// ===== hdl/rcb_ram.sv =====
// rcb_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module rcb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/rcb_div.sv =====
// rcb_div: restoring unsigned divider, one quotient bit per cycle
// depends on rcb_pkg (div_req_t, widths)
`timescale 1ns / 1ps
`default_nettype none

module rcb_div
  import rcb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire div_req_t          req,
  output logic                   busy,
  output logic                   done,
  output logic [DIVD_W-1:0]      quotient
);

  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dsr;
  logic [DIVC_W-1:0] cnt;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              ge;

  assign trial = {rem, quotient[DIVD_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy     <= 1'b1;
        rem      <= '0;
        dsr      <= req.divisor;
        quotient <= req.dividend;
        cnt      <= '0;
      end else if (busy) begin
        rem      <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
        quotient <= {quotient[DIVD_W-2:0], ge};
        cnt      <= cnt + 1'b1;
        if (cnt == DIVC_W'(DIVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rc_branch_voltage_drop_model_top.sv =====
// rc_branch_voltage_drop_model_top: battery cell voltage-drop model, series r plus rc/rl branches
// depends on rcb_pkg, rcb_ram (branch parameters, branch currents), rcb_div
//
// usage
// - configuration over an apb-style port: series_resistance at 0x0, active_branches at 0x4; the
//   user must write them only while idle (not enforced by the block); pready is always high
// - input channel in_valid/in_stall: one transaction is a load (stores one branch, clears its
//   current) or a step (advances every active branch and sums the drop)
// - output channel out_valid/out_stall: exactly one result transaction per input transaction
// - one item at a time; in_stall is high from acceptance until the result is in the output
//   register, which holds it under out_stall while the next item is taken
// - step: the shared divider forms the weight of each active branch with a non-zero time
//   constant; a branch with zero time constant does not use the divider
// - load: the tau of an rl branch comes from the divider, that of an rc branch from the
//   shared multiplier; the dc-resistance walk over the parameter memory follows
// - reset (synchronous) clears the configuration, elapsed time, last drop, output valid and
//   the per-branch current valid bits, so every branch current reads as zero; no clearing pass
// - when the receiver stalls the result waits in the output register and the block stays
//   in its finish state only if a second result is ready before the first is taken
`timescale 1ns / 1ps
`default_nettype none

module rc_branch_voltage_drop_model_top
  import rcb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  // input transactions
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               req_type,
  input  wire logic [3:0]         branch_index,
  input  wire logic [31:0]        branch_resistance,
  input  wire logic [31:0]        branch_reactive,
  input  wire logic               branch_kind,
  input  wire logic signed [31:0] cell_current,
  input  wire logic [31:0]        time_step,
  // result transactions
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      voltage_drop,
  output logic [35:0]             dc_resistance,
  output logic [30:0]             elapsed_seconds
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_LTAU_MUL, ST_LTAU_DIV, ST_LWRITE,
    ST_STEP, ST_SER, ST_BRD, ST_BEVAL, ST_BDIV, ST_BUPD, ST_BCLAMP, ST_BTERM,
    ST_SDONE, ST_DRD, ST_DACC, ST_FIN, ST_MULW
  } state_t;

  state_t state;
  state_t mul_ret;

  // configuration
  logic [31:0] series_res;
  logic [4:0]  active_br;

  // captured transaction
  logic [3:0]         slot_q;
  logic [31:0]        r_in_q;
  logic [31:0]        z_in_q;
  logic               kind_in_q;
  logic signed [31:0] cur_q;
  logic [31:0]        dt_q;

  // working registers
  logic [CNT_W-1:0]       n_q;
  logic [CNT_W-1:0]       k;
  logic [TAU_W-1:0]       tau_q;
  logic [31:0]            r_q;
  logic                   kind_q;
  logic signed [31:0]     ix_q;
  logic                   d_neg;
  logic [32:0]            d_mag;
  logic                   term_neg;
  logic signed [ACC_W-1:0] acc;
  logic [DCS_W-1:0]       dc;
  logic signed [31:0]     last_drop;
  logic [30:0]            elapsed;
  logic [MAX_BRANCHES-1:0] cur_valid;
  logic                   cur_vld_q;

  // shared multiplier, operands and product registered
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] prod;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // memories
  logic [SLOT_W-1:0] k_addr;
  logic [SLOT_W-1:0] slot_addr;
  logic              par_we;
  logic [PAR_W-1:0]  par_rdata;
  logic              cur_we;
  logic [SLOT_W-1:0] cur_waddr;
  logic [31:0]       cur_wdata;
  logic [31:0]       cur_rdata;

  assign k_addr    = k[SLOT_W-1:0];
  assign slot_addr = SLOT_W'(slot_q);

  rcb_ram #(.WIDTH(PAR_W), .DEPTH(MAX_BRANCHES)) u_par_ram (
    .clk   (clk),
    .we    (par_we),
    .waddr (slot_addr),
    .wdata ({kind_in_q, tau_q, r_in_q}),
    .raddr (k_addr),
    .rdata (par_rdata)
  );

  rcb_ram #(.WIDTH(32), .DEPTH(MAX_BRANCHES)) u_cur_ram (
    .clk   (clk),
    .we    (cur_we),
    .waddr (cur_waddr),
    .wdata (cur_wdata),
    .raddr (k_addr),
    .rdata (cur_rdata)
  );

  // shared divider
  div_req_t          div_req;
  logic              div_busy;
  logic              div_done;
  logic [DIVD_W-1:0] div_quo;

  rcb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] x);
    return x[32] ? (~x + 33'd1) : x;
  endfunction

  // datapath around the current table
  logic [31:0]            p_r;
  logic [TAU_W-1:0]       p_tau;
  logic                   p_kind;
  logic signed [31:0]     ix_rd;
  logic signed [32:0]     d_rd;
  logic [32:0]            m_step;
  logic signed [33:0]     ix_upd;
  logic signed [31:0]     ix_fin;
  logic signed [32:0]     d_fin;
  logic [48:0]            term_mag;
  logic signed [ACC_W-1:0] term;
  logic signed [31:0]     acc_sat;
  logic [31:0]            elapsed_sum;
  logic [CNT_W-1:0]       n_used;
  logic                   accept;

  assign p_r    = par_rdata[31:0];
  assign p_tau  = par_rdata[32 +: TAU_W];
  assign p_kind = par_rdata[PAR_W-1];
  assign ix_rd  = cur_vld_q ? $signed(cur_rdata) : 32'sd0;
  assign d_rd   = {cur_q[31], cur_q} - {ix_rd[31], ix_rd};
  assign m_step = prod[64:32];
  assign ix_upd = d_neg ? ({{2{ix_q[31]}}, ix_q} - {1'b0, m_step})
                        : ({{2{ix_q[31]}}, ix_q} + {1'b0, m_step});
  assign ix_fin = (mag32(ix_q) > mag32(cur_q)) ? cur_q : ix_q;
  assign d_fin  = {cur_q[31], cur_q} - {ix_fin[31], ix_fin};
  assign term_mag = prod[64:16];
  assign term   = term_neg ? -$signed({7'd0, term_mag}) : $signed({7'd0, term_mag});
  assign elapsed_sum = {1'b0, elapsed} + {16'd0, dt_q[31:16]};
  assign n_used = (int'(active_br) > MAX_BRANCHES) ? CNT_W'(MAX_BRANCHES)
                                                   : CNT_W'(active_br);
  assign accept = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);

  // drop saturation to 32 bits signed
  always_comb begin
    if (!acc[ACC_W-1] && (|acc[ACC_W-2:31])) begin
      acc_sat = 32'sh7FFF_FFFF;
    end else if (acc[ACC_W-1] && !(&acc[ACC_W-2:31])) begin
      acc_sat = -32'sh8000_0000;
    end else begin
      acc_sat = acc[31:0];
    end
  end

  // divider requests and table writes
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {8'd0, z_in_q, 24'd0};
    div_req.divisor  = {17'd0, r_in_q};
    if (state == ST_LOAD) begin
      div_req.start = (kind_in_q == KIND_RL) && (int'(slot_q) < MAX_BRANCHES);
    end else if (state == ST_BEVAL) begin
      div_req.start    = (p_tau != '0);
      div_req.dividend = {dt_q, 32'd0};
      div_req.divisor  = {1'b0, p_tau} + {17'd0, dt_q};
    end
    par_we    = (state == ST_LWRITE);
    cur_we    = (state == ST_LWRITE) || (state == ST_BCLAMP);
    cur_waddr = (state == ST_LWRITE) ? slot_addr : k_addr;
    cur_wdata = (state == ST_LWRITE) ? 32'd0 : ix_fin;
  end

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ACTIVE) ? {27'd0, active_br} : series_res;

  // sequencer: each table entry is read, updated and written back before the next one is
  // read, so accesses to one entry never overlap
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      last_drop  <= '0;
      elapsed    <= '0;
      cur_valid  <= '0;
      series_res <= '0;
      active_br  <= '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        unique case (paddr[2])
          REG_SERIES: series_res <= pwdata;
          REG_ACTIVE: active_br  <= pwdata[4:0];
        endcase
      end
      // the finish state reloads the output register itself when it is taken
      if (out_valid && !out_stall && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      cur_vld_q <= cur_valid[k_addr];

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            slot_q    <= branch_index;
            r_in_q    <= branch_resistance;
            z_in_q    <= branch_reactive;
            kind_in_q <= branch_kind;
            cur_q     <= cell_current;
            dt_q      <= time_step;
            n_q       <= n_used;
            state     <= (req_type == REQ_LOAD) ? ST_LOAD : ST_STEP;
          end
        end
        // load transaction
        ST_LOAD: begin
          if (int'(slot_q) >= MAX_BRANCHES) begin
            k     <= '0;
            dc    <= DCS_W'(series_res);
            state <= (n_q == '0) ? ST_FIN : ST_DRD;
          end else if (kind_in_q == KIND_RC) begin
            mul_a   <= {1'b0, r_in_q};
            mul_b   <= z_in_q;
            mul_ret <= ST_LTAU_MUL;
            state   <= ST_MULW;
          end else begin
            state <= ST_LTAU_DIV;
          end
        end
        ST_MULW: begin
          state <= mul_ret;
        end
        ST_LTAU_MUL: begin
          tau_q <= {8'd0, prod[63:24]};
          state <= ST_LWRITE;
        end
        ST_LTAU_DIV: begin
          if (div_done) begin
            // quotients above 48 bits (and a zero divisor) saturate
            tau_q <= (|div_quo[DIVD_W-1:TAU_W]) ? '1 : div_quo[TAU_W-1:0];
            state <= ST_LWRITE;
          end
        end
        ST_LWRITE: begin
          cur_valid[slot_addr] <= 1'b1;
          k     <= '0;
          dc    <= DCS_W'(series_res);
          state <= (n_q == '0) ? ST_FIN : ST_DRD;
        end
        // step transaction
        ST_STEP: begin
          elapsed  <= elapsed_sum[31] ? '1 : elapsed_sum[30:0];
          mul_a    <= {1'b0, mag32(cur_q)};
          mul_b    <= series_res;
          term_neg <= cur_q[31];
          mul_ret  <= ST_SER;
          state    <= ST_MULW;
        end
        ST_SER: begin
          acc   <= term;
          k     <= '0;
          state <= (n_q == '0) ? ST_SDONE : ST_BRD;
        end
        ST_BRD: begin
          state <= ST_BEVAL;
        end
        ST_BEVAL: begin
          r_q    <= p_r;
          kind_q <= p_kind;
          if (p_tau == '0) begin
            ix_q  <= cur_q;
            state <= ST_BCLAMP;
          end else begin
            ix_q  <= ix_rd;
            d_neg <= d_rd[32];
            d_mag <= mag33(d_rd);
            state <= ST_BDIV;
          end
        end
        ST_BDIV: begin
          if (div_done) begin
            mul_a   <= d_mag;
            mul_b   <= div_quo[31:0];
            mul_ret <= ST_BUPD;
            state   <= ST_MULW;
          end
        end
        ST_BUPD: begin
          ix_q  <= ix_upd[31:0];
          state <= ST_BCLAMP;
        end
        ST_BCLAMP: begin
          cur_valid[k_addr] <= 1'b1;
          if (kind_q == KIND_RL) begin
            mul_a    <= mag33(d_fin);
            term_neg <= d_fin[32];
          end else begin
            mul_a    <= {1'b0, mag32(ix_fin)};
            term_neg <= ix_fin[31];
          end
          mul_b   <= r_q;
          mul_ret <= ST_BTERM;
          state   <= ST_MULW;
        end
        ST_BTERM: begin
          acc   <= acc + term;
          k     <= k + 1'b1;
          state <= ((k + 1'b1) < n_q) ? ST_BRD : ST_SDONE;
        end
        ST_SDONE: begin
          last_drop <= acc_sat;
          k         <= '0;
          dc        <= DCS_W'(series_res);
          state     <= (n_q == '0) ? ST_FIN : ST_DRD;
        end
        // dc resistance walk over the parameter memory
        ST_DRD: begin
          state <= ST_DACC;
        end
        ST_DACC: begin
          if (p_kind == KIND_RC) begin
            dc <= dc + DCS_W'(p_r);
          end
          k     <= k + 1'b1;
          state <= ((k + 1'b1) < n_q) ? ST_DRD : ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid || !out_stall) begin
            voltage_drop    <= last_drop;
            dc_resistance   <= (64'(dc) > 64'h0000_000F_FFFF_FFFF) ? '1 : 36'(dc);
            elapsed_seconds <= elapsed;
            out_valid       <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // the divider is only started when idle
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_busy)
    else $error("divider started while busy");

  // the branch walk never runs past the active branch count
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BTERM || state == ST_DACC) |-> (k < n_q))
    else $error("branch walk past active count");

  // an accepted transaction leaves the idle state
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("accepted transaction not started");

  // a divider result only arrives while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_BDIV || state == ST_LTAU_DIV))
    else $error("divider result without a waiting state");
`endif

endmodule

`default_nettype wire
